/* rtl/core/vdm_pkg.sv */
// ----------------------------------------------------------------------------
// vdm_pkg: shared types and constants for the vector distance core
// Payload structs, metric codes and the controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
package vdm_pkg;

  // element and accumulator sizing
  localparam int ELEMENT_WIDTH = 32;
  localparam int FIELD_W       = 32;
  localparam int ACC_W         = 64;
  localparam int DIST_W        = 63;
  localparam int SQ_W          = 2 * ELEMENT_WIDTH;
  localparam int ROOT_W        = ACC_W / 2;
  localparam int REM_W         = ROOT_W + 3;
  localparam int CNT_W         = $clog2(ROOT_W);
  localparam int MODE_W        = 2;

  // largest value of a 63-bit distance
  localparam logic [ACC_W:0] MAX_DIST = {2'b00, {DIST_W{1'b1}}};

  // metric codes
  localparam logic [MODE_W-1:0] MODE_CHEB = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EUC  = 2'd2;

  // input item
  typedef struct packed {
    logic signed [FIELD_W-1:0] elem_a;
    logic signed [FIELD_W-1:0] elem_b;
    logic                      last_element;
  } vdm_in_t;

  // result item
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } vdm_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic diff_en;
    logic mul_en;
    logic acc_en;
    logic root_init;
    logic root_step;
    logic out_load;
  } vdm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic is_euc;
    logic root_done;
    logic out_free;
  } vdm_sts_t;

endpackage

/* rtl/core/vdm_ctrl.sv */
// ----------------------------------------------------------------------------
// vdm_ctrl: sequencing state machine
// Walks each item through difference, square and accumulate; on the final
// pair it runs the square root if Euclidean and loads the result register.
// ----------------------------------------------------------------------------
module vdm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vdm_pkg::vdm_sts_t  sts_i,
  output vdm_pkg::vdm_cmd_t  cmd_o
);
  import vdm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_RINIT = 3'd4;
  localparam logic [2:0] S_ROOT  = 3'd5;
  localparam logic [2:0] S_LOAD  = 3'd6;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (sts_i.is_euc) begin
          state_d = S_RINIT;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_RINIT: begin
        cmd_o.root_init = 1'b1;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_done) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/vdm_dpath.sv */
// ----------------------------------------------------------------------------
// vdm_dpath: distance datapath
// Absolute difference, registered squarer, accumulator (saturating sum or
// running max), a one-bit-per-cycle square root unit and the result register.
// ----------------------------------------------------------------------------
module vdm_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_data_i,
  input  vdm_pkg::vdm_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vdm_pkg::vdm_out_t  out_data_o,
  input  vdm_pkg::vdm_cmd_t  cmd_i,
  output vdm_pkg::vdm_sts_t  sts_o
);
  import vdm_pkg::*;

  logic [MODE_W-1:0]        mode_q;
  vdm_in_t                  in_q;
  logic [ELEMENT_WIDTH-1:0] diff_q;
  logic [SQ_W-1:0]          sq_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic                     clip_q, clip_d;
  logic [ACC_W-1:0]         rad_q;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [ROOT_W-1:0]        root_q, root_d;
  logic [CNT_W-1:0]         cnt_q;
  logic                     out_valid_q;
  vdm_out_t                 out_q;

  logic                     is_euc;
  logic signed [ELEMENT_WIDTH:0] a_ext, b_ext, sub;
  logic [ELEMENT_WIDTH:0]   sub_abs;
  logic [ACC_W-1:0]         addend;
  logic [ACC_W:0]           sum;
  logic [REM_W-1:0]         rem_sh, trial;

  assign is_euc = (mode_q == MODE_EUC);

  // metric register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CHEB;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // absolute difference of the low element bits
  always_comb begin
    a_ext   = {in_q.elem_a[ELEMENT_WIDTH-1], in_q.elem_a[ELEMENT_WIDTH-1:0]};
    b_ext   = {in_q.elem_b[ELEMENT_WIDTH-1], in_q.elem_b[ELEMENT_WIDTH-1:0]};
    sub     = a_ext - b_ext;
    sub_abs = sub[ELEMENT_WIDTH] ? (~sub + 1'b1) : sub;
  end

  // accumulator update under the current metric
  always_comb begin
    addend = is_euc ? ACC_W'(sq_q) : ACC_W'(diff_q);
    sum    = {1'b0, acc_q} + {1'b0, addend};
    acc_d  = acc_q;
    clip_d = clip_q;
    case (mode_q)
      MODE_MAN: begin
        if (sum > MAX_DIST) begin
          acc_d  = MAX_DIST[ACC_W-1:0];
          clip_d = 1'b1;
        end else begin
          acc_d = sum[ACC_W-1:0];
        end
      end
      MODE_EUC: begin
        if (sum[ACC_W]) begin
          acc_d  = {ACC_W{1'b1}};
          clip_d = 1'b1;
        end else begin
          acc_d = sum[ACC_W-1:0];
        end
      end
      default: begin
        if (addend > acc_q) begin
          acc_d = addend;
        end
      end
    endcase
  end

  // one root bit per step
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[ACC_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.diff_en) begin
      diff_q <= sub_abs[ELEMENT_WIDTH-1:0];
    end
    if (cmd_i.mul_en) begin
      sq_q <= SQ_W'(diff_q) * SQ_W'(diff_q);
    end
    if (cmd_i.root_init) begin
      rad_q  <= acc_q;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_q.distance  <= is_euc ? DIST_W'(root_q) : acc_q[DIST_W-1:0];
      out_q.saturated <= clip_q;
    end
  end

  // accumulator and clip flag, cleared once the result is taken in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      acc_q  <= acc_d;
      clip_q <= clip_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status to the controller
  assign sts_o.last      = in_q.last_element;
  assign sts_o.is_euc    = is_euc;
  assign sts_o.root_done = (cnt_q == CNT_W'(ROOT_W - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

/* rtl/core/vector_distance_metric_core.sv */
// ----------------------------------------------------------------------------
// vector_distance_metric_core: streaming vector distance
// Chebyshev, Manhattan or Euclidean distance over element pairs, one pair
// per item, with a result item after the pair marked last.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------
//  in       | input     | in_valid_i/in_ready_o | elem_a, elem_b, last_element
//  out      | output    | out_valid_o/out_ready_i | distance, saturated
//  cfg      | input     | cfg_we_i              | metric_mode (2 bits)
//
// An element pair passes through capture, difference, square and accumulate.
// A final pair then loads the result; for Euclidean the square root unit
// first retires one root bit per cycle over 32 steps.
// Reset clears the accumulator, clip flag, metric and result valid.
// A result waits in its own register; only a second final pair stalls on it.
// ----------------------------------------------------------------------------
module vector_distance_metric_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vdm_pkg::vdm_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vdm_pkg::vdm_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_data_i
);
  import vdm_pkg::*;

  vdm_cmd_t cmd;
  vdm_sts_t sts;

  // sequencer
  vdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic
  vdm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
